[rtl/core/gtp_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and helpers for the go-to-point velocity controller.
// No dependencies.
package gtp_pkg;

	localparam int FRAC_BITS     = 16;
	localparam int CORDIC_STAGES = 18;

	// Field and datapath widths.
	localparam int POS_W   = 32;
	localparam int HEAD_W  = 21;
	localparam int SPEED_W = 18;
	localparam int TURN_W  = 20;
	localparam int CFG_W   = 19;
	localparam int XW      = 36;  // CORDIC x and y, room for gain growth
	localparam int ZW      = 21;  // angles
	localparam int DIST_W  = 35;
	localparam int AERR_W  = 18;
	localparam int MAG_W   = 22;

	localparam logic [63:0] PI_Q30 = 64'd3373259426;
	localparam logic [27:0] K_Q28  = 28'd163008219;
	localparam int          RND_SH = 30 - FRAC_BITS;

	localparam logic signed [ZW-1:0] PI_Q =
		ZW'((PI_Q30 + (64'd1 << (RND_SH - 1))) >> RND_SH);
	localparam logic signed [ZW-1:0] TWO_PI = ZW'(2 * PI_Q);

	// Register indexes of the configuration port.
	localparam logic [2:0] REG_HEADING_GAIN = 3'd0;
	localparam logic [2:0] REG_MAX_SPEED    = 3'd1;
	localparam logic [2:0] REG_MIN_SPEED    = 3'd2;
	localparam logic [2:0] REG_MAX_TURN     = 3'd3;
	localparam logic [2:0] REG_MIN_TURN     = 3'd4;
	localparam logic [2:0] REG_STOP_DIST    = 3'd5;
	localparam logic [2:0] REG_TURN_STOP    = 3'd6;
	localparam logic [2:0] REG_HEAD_TOL     = 3'd7;

	localparam logic [31:0] ATAN_Q30 [24] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
		32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
		32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
		32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
		32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
		32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
	};

	// Arctangent of 2^-i, rounded to FRAC_BITS fraction bits.
	function automatic logic signed [ZW-1:0] atan_frac(input int i);
		logic [32:0] t;
		t = {1'b0, ATAN_Q30[i]} + (33'd1 << (RND_SH - 1));
		return ZW'(t >> RND_SH);
	endfunction

	// One step of the heading reduction into (-pi, pi].
	function automatic logic signed [ZW-1:0] wrap_step(input logic signed [ZW-1:0] h);
		if (h > PI_Q) begin
			return h - TWO_PI;
		end else if (h <= -PI_Q) begin
			return h + TWO_PI;
		end
		return h;
	endfunction

endpackage

[rtl/core/go_to_point_velocity_controller.sv]
`timescale 1ns / 1ps
// Go-to-point velocity controller: CORDIC vectoring pipeline plus command law.
// Depends on gtp_pkg.
//
// Usage:
//   Input transactions carry a goal point, the robot position and its heading
//   on in_valid/in_ready. Each one yields exactly one output transaction with
//   speed_cmd, turn_cmd and arrived on out_valid/out_ready.
//   The configuration port writes register cfg_index with cfg_data whenever
//   cfg_wr_en is high; write it only while no transaction is in flight.
//   The pipeline has 24 register stages: one subtract stage, one half-plane
//   stage, CORDIC_STAGES vectoring stages, and four stages for the gain
//   multiply, the angle error and the limits. Throughput is one transaction
//   per cycle while the output is not stalled; each CORDIC iteration has its
//   own register stage, so the vectoring unit sets the depth, not the rate.
//   The whole pipeline advances together. When the output holds a result that
//   the receiver does not take, every stage holds and in_ready drops; nothing
//   is lost or repeated. in_ready is high whenever the output is empty or
//   being taken.
//   Reset clears all valid bits and loads the default gains and limits.
module go_to_point_velocity_controller
	import gtp_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [2:0]               cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [POS_W-1:0]  goal_x,
	input  logic signed [POS_W-1:0]  goal_y,
	input  logic signed [POS_W-1:0]  pos_x,
	input  logic signed [POS_W-1:0]  pos_y,
	input  logic signed [HEAD_W-1:0] heading,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [SPEED_W-1:0]       speed_cmd,
	output logic signed [TURN_W-1:0] turn_cmd,
	output logic                     arrived
);

	localparam int N = CORDIC_STAGES;

	logic [11:0]       heading_gain_q;
	logic [17:0]       max_speed_q, min_speed_q, stop_dist_q, turn_stop_q;
	logic [18:0]       max_turn_q, min_turn_q, head_tol_q;

	logic              adv;
	logic              v_s1, v_s2, v_s3, v_s4, v_s5;
	logic              cv_s [N+1];

	logic signed [POS_W:0]   dx_s1, dy_s1;
	logic signed [HEAD_W-1:0] h_s1;

	logic signed [XW-1:0] cx_s [N+1];
	logic signed [XW-1:0] cy_s [N+1];
	logic signed [ZW-1:0] cz_s [N+1];
	logic signed [ZW-1:0] ch_s [N+1];
	logic signed [XW-1:0] nx [N];
	logic signed [XW-1:0] ny [N];
	logic signed [ZW-1:0] nz [N];
	logic signed [ZW-1:0] nh [N];

	logic signed [XW-1:0] px0, py0;
	logic signed [ZW-1:0] pz0;

	logic [45:0]          pp_lo_s2;
	logic [44:0]          pp_hi_s2;
	logic signed [ZW-1:0] err_s2, bear_w;
	logic [63:0]          dist_sum;
	logic [DIST_W-1:0]    dist_s3;
	logic signed [ZW-1:0] err_w;
	logic [AERR_W-1:0]    aerr_s3;
	logic                 neg_s3;
	logic [29:0]          prod;
	logic [MAG_W-1:0]     mag_s4;
	logic                 tzero_s4, neg_s4;
	logic [SPEED_W-1:0]   speed_s4, speed_n;
	logic [18:0]          w_n;
	logic [SPEED_W-1:0]   speed_s5;
	logic signed [TURN_W-1:0] turn_s5;
	logic                 arr_s5;

	assign adv      = !v_s5 || out_ready;
	assign in_ready = adv;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heading_gain_q <= 12'd512;
			max_speed_q    <= 18'd26214;
			min_speed_q    <= 18'd6554;
			max_turn_q     <= 19'd57191;
			min_turn_q     <= 19'd5719;
			stop_dist_q    <= 18'd3277;
			turn_stop_q    <= 18'd6554;
			head_tol_q     <= 19'd1144;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_HEADING_GAIN: heading_gain_q <= cfg_data[11:0];
				REG_MAX_SPEED:    max_speed_q    <= cfg_data[17:0];
				REG_MIN_SPEED:    min_speed_q    <= cfg_data[17:0];
				REG_MAX_TURN:     max_turn_q     <= cfg_data;
				REG_MIN_TURN:     min_turn_q     <= cfg_data;
				REG_STOP_DIST:    stop_dist_q    <= cfg_data[17:0];
				REG_TURN_STOP:    turn_stop_q    <= cfg_data[17:0];
				REG_HEAD_TOL:     head_tol_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			for (int k = 0; k <= N; k++) begin
				cv_s[k] <= 1'b0;
			end
		end else if (adv) begin
			v_s1     <= in_valid;
			cv_s[0]  <= v_s1;
			for (int k = 0; k < N; k++) begin
				cv_s[k+1] <= cv_s[k];
			end
			v_s2 <= cv_s[N];
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// A vector in the left half plane is first turned by pi.
	always_comb begin
		px0 = XW'(dx_s1);
		py0 = XW'(dy_s1);
		pz0 = '0;
		if (dx_s1 < 0) begin
			pz0 = (dy_s1 >= 0) ? PI_Q : -PI_Q;
			px0 = -XW'(dx_s1);
			py0 = -XW'(dy_s1);
		end
	end

	// One vectoring iteration per stage; the heading is reduced alongside.
	always_comb begin
		for (int k = 0; k < N; k++) begin
			if (!cy_s[k][XW-1]) begin
				nx[k] = cx_s[k] + (cy_s[k] >>> k);
				ny[k] = cy_s[k] - (cx_s[k] >>> k);
				nz[k] = cz_s[k] + atan_frac(k);
			end else begin
				nx[k] = cx_s[k] - (cy_s[k] >>> k);
				ny[k] = cy_s[k] + (cx_s[k] >>> k);
				nz[k] = cz_s[k] - atan_frac(k);
			end
			nh[k] = wrap_step(ch_s[k]);
		end
	end

	always_comb begin
		bear_w = wrap_step(cz_s[N]);
		dist_sum = {1'b0, pp_hi_s2, 18'd0} + {18'd0, pp_lo_s2} + (64'd1 << 27);
		err_w = err_s2;
		if (err_s2 > PI_Q) begin
			err_w = err_s2 - TWO_PI;
		end else if (err_s2 < -PI_Q) begin
			err_w = err_s2 + TWO_PI;
		end
		prod = 30'(aerr_s3) * 30'(heading_gain_q);

		if (dist_s3 == '0) begin
			speed_n = '0;
		end else if (dist_s3 > DIST_W'({max_speed_q, 1'b0})) begin
			speed_n = max_speed_q;
		end else begin
			speed_n = dist_s3[SPEED_W:1];
			if (speed_n < min_speed_q) begin
				speed_n = min_speed_q;
			end
		end
		if (dist_s3 <= DIST_W'(stop_dist_q)) begin
			speed_n = '0;
		end

		if (mag_s4 == '0) begin
			w_n = '0;
		end else if (mag_s4 > MAG_W'(max_turn_q)) begin
			w_n = max_turn_q;
		end else if (mag_s4 < MAG_W'(min_turn_q)) begin
			w_n = min_turn_q;
		end else begin
			w_n = mag_s4[18:0];
		end
		if (tzero_s4) begin
			w_n = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1 <= (POS_W+1)'(goal_x) - (POS_W+1)'(pos_x);
			dy_s1 <= (POS_W+1)'(goal_y) - (POS_W+1)'(pos_y);
			h_s1  <= heading;

			cx_s[0] <= px0;
			cy_s[0] <= py0;
			cz_s[0] <= pz0;
			ch_s[0] <= h_s1;
			for (int k = 0; k < N; k++) begin
				cx_s[k+1] <= nx[k];
				cy_s[k+1] <= ny[k];
				cz_s[k+1] <= nz[k];
				ch_s[k+1] <= nh[k];
			end

			// The gain multiply is split into two narrow partial products.
			pp_lo_s2 <= 46'(cx_s[N][17:0]) * 46'(K_Q28);
			pp_hi_s2 <= 45'(cx_s[N][34:18]) * 45'(K_Q28);
			err_s2   <= bear_w - ch_s[N];

			dist_s3 <= dist_sum[28 +: DIST_W];
			neg_s3  <= err_w[ZW-1];
			aerr_s3 <= err_w[ZW-1] ? AERR_W'(-err_w) : AERR_W'(err_w);

			mag_s4   <= prod[29:8];
			neg_s4   <= neg_s3;
			tzero_s4 <= (19'(aerr_s3) <= head_tol_q) || (dist_s3 <= DIST_W'(turn_stop_q));
			speed_s4 <= speed_n;

			speed_s5 <= speed_s4;
			turn_s5  <= neg_s4 ? -TURN_W'(w_n) : TURN_W'(w_n);
			arr_s5   <= (speed_s4 == '0) && (w_n == '0);
		end
	end

	assign out_valid = v_s5;
	assign speed_cmd = speed_s5;
	assign turn_cmd  = turn_s5;
	assign arrived   = arr_s5;

endmodule

[rtl/core/gtp_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the go-to-point velocity controller, with its bind.
// Depends on gtp_pkg.
module gtp_checker
	import gtp_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_ready,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic [SPEED_W-1:0]       speed_cmd,
	input logic signed [TURN_W-1:0] turn_cmd,
	input logic                     arrived
);

	// A stalled output transaction keeps its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(speed_cmd) &&
		$stable(turn_cmd) && $stable(arrived))
		else $error("output changed while stalled");

	// Arrived means both commands are zero.
	a_arrived: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> arrived == (speed_cmd == '0 && turn_cmd == '0))
		else $error("arrived flag disagrees with commands");

	// An empty output never blocks the input side.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// The turn command never reaches the most negative code.
	a_turn: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> turn_cmd != {1'b1, {(TURN_W-1){1'b0}}})
		else $error("turn command out of range");

endmodule

bind go_to_point_velocity_controller gtp_checker u_gtp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.speed_cmd (speed_cmd),
	.turn_cmd  (turn_cmd),
	.arrived   (arrived)
);
